### rtl/wsc_pkg.sv
// Package for the wavetable sound channel: request kinds, control register
// numbers, volume codes and the period reload function.
// No dependencies.
`default_nettype none

package wsc_pkg;

    // Request kinds carried on req_type
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_LENGTH  = 2'd1;
    localparam logic [1:0] REQ_REG     = 2'd2;
    localparam logic [1:0] REQ_PATTERN = 2'd3;

    // Control register numbers
    localparam logic [2:0] REG_DAC     = 3'd0;
    localparam logic [2:0] REG_LENGTH  = 3'd1;
    localparam logic [2:0] REG_VOLUME  = 3'd2;
    localparam logic [2:0] REG_FREQ_LO = 3'd3;
    localparam logic [2:0] REG_CONTROL = 3'd4;

    // Volume codes
    localparam logic [1:0] VOL_MUTE    = 2'd0;
    localparam logic [1:0] VOL_FULL    = 2'd1;
    localparam logic [1:0] VOL_HALF    = 2'd2;
    localparam logic [1:0] VOL_QUARTER = 2'd3;

    localparam int PATTERN_BYTES = 16;
    localparam logic [12:0] PERIOD_MAX = 13'd4096;

    typedef logic [7:0] t_pattern_byte;

    // Reload value 2*(2048-freq): 2 .. 4096
    function automatic logic [12:0] period_reload(input logic [10:0] freq);
        logic [11:0] diff;
        diff = 12'd2048 - {1'b0, freq};
        return {diff, 1'b0};
    endfunction

endpackage

`default_nettype wire

### rtl/wavetable_sound_channel.sv
// Wavetable sound channel top level: control registers, 16-byte pattern RAM
// and the two-stage request pipeline. Depends on wsc_pkg.
`default_nettype none

// A 4-bit wavetable voice. Every input beat is a sample tick, a length clock,
// a control register write or a pattern RAM byte write, and every input beat
// yields exactly one output beat carrying the current signed 16-bit output and
// the channel enable flag. The block takes one beat per cycle while the output
// side is not stalled. Stage 0 updates the control registers and issues the
// pattern RAM read at the accepting edge; stage 1 then picks the nibble, scales
// it and loads the output register. The synchronous pattern RAM read in stage 0
// is why the nibble pick and scaling sit in stage 1. A result waiting on the
// output does not stop the next beat: stage 1 holds one more beat before the
// input side stalls.
// Pattern RAM contents are undefined until written; no clearing pass is run.
module wavetable_sound_channel (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_req_type,
    input  wire  [2:0]  i_reg_select,
    input  wire  [3:0]  i_pattern_addr,
    input  wire  [7:0]  i_write_data,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic signed [15:0] o_audio_out,
    output logic        o_channel_active
);

    // ------------------------------------------------------------------
    // Channel state
    // ------------------------------------------------------------------
    logic        r_dac_on,        n_dac_on;
    logic [8:0]  r_length_reload, n_length_reload;
    logic [1:0]  r_volume_code,   n_volume_code;
    logic [10:0] r_freq_value,    n_freq_value;
    logic        r_length_enable, n_length_enable;
    logic        r_chan_enabled,  n_chan_enabled;
    logic [8:0]  r_length_left,   n_length_left;
    logic [12:0] r_period_left,   n_period_left;
    logic [4:0]  r_wave_position, n_wave_position;
    logic        s0_wrap;
    logic        s0_mute;

    // Pattern RAM: 16 bytes, high nibble is the even sample
    wsc_pkg::t_pattern_byte r_pattern_ram [0:wsc_pkg::PATTERN_BYTES-1];
    wsc_pkg::t_pattern_byte r_rdata;

    // Stage 1 registers
    logic        r_s1_valid;
    logic        r_s1_tick;
    logic        r_s1_wrap;
    logic        r_s1_mute;
    logic        r_s1_nib_lo;
    logic [1:0]  r_s1_volume;
    logic        r_s1_active;

    // State owned by stage 1
    logic [3:0]         r_current_sample;
    logic signed [15:0] r_out_value;

    // Output register
    logic               r_out_valid;
    logic signed [15:0] r_audio_out;
    logic               r_channel_active;

    logic in_fire;
    logic s1_advance;
    logic s1_move;

    // Output register frees when empty or being taken; stage 1 frees when
    // empty or moving into the output register.
    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_fire    = i_in_valid && o_in_ready;
    assign s1_move    = r_s1_valid && s1_advance;

    // ------------------------------------------------------------------
    // Stage 0: request decode and control register update
    // ------------------------------------------------------------------
    always_comb begin
        n_dac_on        = r_dac_on;
        n_length_reload = r_length_reload;
        n_volume_code   = r_volume_code;
        n_freq_value    = r_freq_value;
        n_length_enable = r_length_enable;
        n_chan_enabled  = r_chan_enabled;
        n_length_left   = r_length_left;
        n_period_left   = r_period_left;
        n_wave_position = r_wave_position;
        s0_wrap         = 1'b0;
        case (i_req_type)
            wsc_pkg::REQ_TICK: begin
                // Count down; an idle counter (zero) stays put
                if (r_period_left != 13'd0) begin
                    if (r_period_left == 13'd1) begin
                        n_period_left   = wsc_pkg::period_reload(r_freq_value);
                        n_wave_position = r_wave_position + 5'd1;
                        s0_wrap         = 1'b1;
                    end else begin
                        n_period_left = r_period_left - 13'd1;
                    end
                end
            end
            wsc_pkg::REQ_LENGTH: begin
                if (r_length_enable && r_length_left != 9'd0) begin
                    n_length_left = r_length_left - 9'd1;
                end
            end
            wsc_pkg::REQ_REG: begin
                case (i_reg_select)
                    wsc_pkg::REG_DAC: begin
                        n_dac_on = i_write_data[7];
                        if (!i_write_data[7]) begin
                            n_chan_enabled = 1'b0;
                        end
                    end
                    wsc_pkg::REG_LENGTH: begin
                        n_length_reload = 9'd256 - {1'b0, i_write_data};
                        n_length_left   = 9'd256 - {1'b0, i_write_data};
                    end
                    wsc_pkg::REG_VOLUME: begin
                        n_volume_code = i_write_data[6:5];
                    end
                    wsc_pkg::REG_FREQ_LO: begin
                        n_freq_value = {r_freq_value[10:8], i_write_data};
                    end
                    wsc_pkg::REG_CONTROL: begin
                        n_length_enable = i_write_data[6];
                        n_freq_value    = {i_write_data[2:0], r_freq_value[7:0]};
                        // Trigger only takes hold with the DAC on
                        if (i_write_data[7] && r_dac_on) begin
                            n_chan_enabled  = 1'b1;
                            n_wave_position = 5'd0;
                            n_length_left   = r_length_reload;
                        end
                    end
                    default: begin
                    end
                endcase
                // Any register write, even to an unused number, reloads the period
                n_period_left = wsc_pkg::period_reload(n_freq_value);
            end
            default: begin
                // Pattern write: handled by the RAM block
            end
        endcase
    end

    // Mute when disabled or when an enabled length counter has run out
    assign s0_mute = !n_chan_enabled || (n_length_enable && n_length_left == 9'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac_on        <= 1'b0;
            r_length_reload <= 9'd0;
            r_volume_code   <= 2'd0;
            r_freq_value    <= 11'd0;
            r_length_enable <= 1'b0;
            r_chan_enabled  <= 1'b0;
            r_length_left   <= 9'd0;
            r_period_left   <= 13'd0;
            r_wave_position <= 5'd0;
        end else if (in_fire) begin
            r_dac_on        <= n_dac_on;
            r_length_reload <= n_length_reload;
            r_volume_code   <= n_volume_code;
            r_freq_value    <= n_freq_value;
            r_length_enable <= n_length_enable;
            r_chan_enabled  <= n_chan_enabled;
            r_length_left   <= n_length_left;
            r_period_left   <= n_period_left;
            r_wave_position <= n_wave_position;
        end
    end

    // Pattern RAM: write a byte on a pattern beat, read the byte holding the
    // new position on every accepted beat. A pattern beat reads the old
    // contents at its own edge, but only ticks use the read data, and a tick
    // always comes at a later edge than any write before it.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (i_req_type == wsc_pkg::REQ_PATTERN) begin
                r_pattern_ram[i_pattern_addr] <= i_write_data;
            end
            r_rdata <= r_pattern_ram[n_wave_position[4:1]];
        end
    end

    // Stage 1 control and snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_tick   <= (i_req_type == wsc_pkg::REQ_TICK);
            r_s1_wrap   <= s0_wrap;
            r_s1_mute   <= s0_mute;
            r_s1_nib_lo <= n_wave_position[0];
            r_s1_volume <= n_volume_code;
            r_s1_active <= n_chan_enabled;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sample select and volume scaling
    // ------------------------------------------------------------------
    logic [3:0]         s1_sample;
    logic [3:0]         s1_eff;
    logic signed [16:0] s1_full;
    logic signed [16:0] s1_scaled;
    logic signed [15:0] s1_audio;

    always_comb begin
        if (r_s1_wrap) begin
            s1_sample = r_s1_nib_lo ? r_rdata[3:0] : r_rdata[7:4];
        end else begin
            s1_sample = r_current_sample;
        end
        s1_eff = r_s1_mute ? 4'd0 : s1_sample;
        // sample*4369 - 32768 equals the nibble repeated four times with
        // the top bit flipped
        s1_full = {{2{~s1_eff[3]}}, s1_eff[2:0], s1_eff, s1_eff, s1_eff};
        // Shift right with rounding toward zero
        case (r_s1_volume)
            wsc_pkg::VOL_MUTE:    s1_scaled = 17'sd0;
            wsc_pkg::VOL_FULL:    s1_scaled = s1_full;
            wsc_pkg::VOL_HALF:
                s1_scaled = (s1_full + (s1_full[16] ? 17'sd1 : 17'sd0)) >>> 1;
            wsc_pkg::VOL_QUARTER:
                s1_scaled = (s1_full + (s1_full[16] ? 17'sd3 : 17'sd0)) >>> 2;
            default:              s1_scaled = 17'sd0;
        endcase
        s1_audio = r_s1_tick ? s1_scaled[15:0] : r_out_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_sample <= 4'd0;
            r_out_value      <= 16'sd0;
        end else if (s1_move && r_s1_tick) begin
            r_current_sample <= s1_sample;
            r_out_value      <= s1_scaled[15:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_audio_out      <= s1_audio;
            r_channel_active <= r_s1_active;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_audio_out      = r_audio_out;
    assign o_channel_active = r_channel_active;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_enable_needs_dac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan_enabled |-> r_dac_on)
        else $error("channel enabled while DAC is off");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period_left <= wsc_pkg::PERIOD_MAX)
        else $error("period counter out of range");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_advance) |=> (r_s1_valid && $stable(r_rdata)))
        else $error("stalled stage 1 lost its pattern data");

endmodule

`default_nettype wire

### tb/sv/wavetable_channel_checker.sv
// Checker for the wavetable sound channel: tracks the channel state from the
// accepted input beats, predicts every output beat and compares it.
// Depends on wsc_pkg for request kinds, register numbers and volume codes.
module wavetable_channel_checker
    import wsc_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire [1:0]         i_req_type,
    input  wire [2:0]         i_reg_select,
    input  wire [3:0]         i_pattern_addr,
    input  wire [7:0]         i_write_data,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire signed [15:0] i_audio_out,
    input  wire               i_channel_active,
    output int                o_error_count,
    output int                o_outputs_checked,
    output int                o_outputs_pending,
    output int                o_wave_steps
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] audio;
        logic        active;
    } t_channel_out;

    t_channel_out expected_outputs[$];

    // Tracked channel state
    logic        dac_on;
    logic        len_en;
    logic        chan_en;
    logic [8:0]  len_reload;
    logic [8:0]  len_left;
    logic [1:0]  vol;
    logic [10:0] freq;
    logic [12:0] period_left;
    logic [4:0]  wave_pos;
    logic [3:0]  cur_sample;
    logic [3:0]  wave_ram [32];
    logic [15:0] out_level;

    int mismatches;
    int checked;
    int wave_steps;

    function automatic logic [12:0] period_for(input logic [10:0] f);
        return 13'(2 * (2048 - int'(f)));
    endfunction

    // Sample to signed level, then the volume shift (truncates toward zero)
    function automatic logic [15:0] scaled_level();
        int s;
        int v;
        s = (chan_en && !(len_en && len_left == 9'd0)) ? int'(cur_sample) : 0;
        v = s * 4369 - 32768;
        case (vol)
            VOL_MUTE:    v = 0;
            VOL_FULL:    ;
            VOL_HALF:    v = v / 2;
            default:     v = v / 4;
        endcase
        return 16'(v);
    endfunction

    task automatic advance_channel(input logic [1:0] kind, input logic [2:0] sel,
                                   input logic [3:0] addr, input logic [7:0] data);
        case (kind)
            REQ_TICK: begin
                // idle period counter: no count, no advance
                if (period_left != 13'd0) begin
                    period_left = period_left - 13'd1;
                    if (period_left == 13'd0) begin
                        period_left = period_for(freq);
                        wave_pos = wave_pos + 5'd1;
                        cur_sample = wave_ram[wave_pos];
                        wave_steps++;
                    end
                end
                out_level = scaled_level();
            end
            REQ_LENGTH: begin
                if (len_en && len_left != 9'd0) len_left = len_left - 9'd1;
            end
            REQ_REG: begin
                case (sel)
                    REG_DAC: begin
                        dac_on = data[7];
                        if (!data[7]) chan_en = 1'b0;
                    end
                    REG_LENGTH: begin
                        len_reload = 9'd256 - {1'b0, data};
                        len_left = len_reload;
                    end
                    REG_VOLUME:  vol = data[6:5];
                    REG_FREQ_LO: freq[7:0] = data;
                    REG_CONTROL: begin
                        len_en = data[6];
                        freq[10:8] = data[2:0];
                        if (data[7] && dac_on) begin
                            chan_en = 1'b1;
                            wave_pos = 5'd0;
                            len_left = len_reload;
                        end
                    end
                    default: ;
                endcase
                period_left = period_for(freq);
            end
            default: begin
                wave_ram[{addr, 1'b0}] = data[7:4];
                wave_ram[{addr, 1'b1}] = data[3:0];
            end
        endcase
        expected_outputs.push_back(t_channel_out'{audio: out_level, active: chan_en});
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_channel_out exp_out;
        if (!i_rst_n) begin
            dac_on = 1'b0;
            len_en = 1'b0;
            chan_en = 1'b0;
            len_reload = '0;
            len_left = '0;
            vol = VOL_MUTE;
            freq = '0;
            period_left = '0;
            wave_pos = '0;
            cur_sample = '0;
            out_level = '0;
            mismatches = 0;
            checked = 0;
            wave_steps = 0;
            expected_outputs.delete();
        end else begin
            // take the input beat first so a same-edge output still lines up
            if (i_in_valid && i_in_ready)
                advance_channel(i_req_type, i_reg_select, i_pattern_addr, i_write_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch("output beat with nothing expected",
                                    int'(i_audio_out), 0);
                end else begin
                    exp_out = expected_outputs.pop_front();
                    checked++;
                    if (i_audio_out !== exp_out.audio)
                        report_mismatch("audio_out", int'(i_audio_out),
                                        int'($signed(exp_out.audio)));
                    if (i_channel_active !== exp_out.active)
                        report_mismatch("channel_active", int'(i_channel_active),
                                        int'(exp_out.active));
                end
            end
        end
        o_error_count     <= mismatches;
        o_outputs_checked <= checked;
        o_outputs_pending <= expected_outputs.size();
        o_wave_steps      <= wave_steps;
    end

endmodule

### tb/sv/tb_wavetable_sound_channel.sv
// Top of the wavetable sound channel testbench: clock, reset, stimulus and
// output-side flow control. Depends on wsc_pkg, the channel RTL and
// wavetable_channel_checker, which predicts and compares the outputs.
module tb_wavetable_sound_channel;
    timeunit 1ns;
    timeprecision 1ps;

    import wsc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int TOTAL_BEATS  = 1100;
    localparam int QUIET_BEATS  = 150;   // tail of the run without any idling
    localparam int HOLD_AT      = 350;   // beat count that starts the long output stall
    localparam int PAUSE_AT     = 700;   // beat count where the sender drains the block
    localparam int LONG_HOLD    = 300;   // cycles of the long output stall
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;

    // Register numbers with no register behind them
    localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_TICK;
    logic [2:0]  reg_select = REG_DAC;
    logic [3:0]  pattern_addr = 4'd0;
    logic [7:0]  write_data = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] audio_out;
    logic        channel_active;

    int error_count;
    int outputs_checked;
    int outputs_pending;
    int wave_steps;

    int  cycle_count = 0;
    int  items_sent = 0;
    int  tick_beats = 0;
    int  length_beats = 0;
    int  reg_beats = 0;
    int  pattern_beats = 0;
    bit  quiet = 1'b0;          // no idling on either side once set
    bit  hold_request = 1'b0;   // asks the receiver for the long stall

    always #(CLK_PERIOD / 2) clk = ~clk;

    wavetable_sound_channel i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_reg_select     (reg_select),
        .i_pattern_addr   (pattern_addr),
        .i_write_data     (write_data),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_audio_out      (audio_out),
        .o_channel_active (channel_active)
    );

    wavetable_channel_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_req_type        (req_type),
        .i_reg_select      (reg_select),
        .i_pattern_addr    (pattern_addr),
        .i_write_data      (write_data),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_audio_out       (audio_out),
        .i_channel_active  (channel_active),
        .o_error_count     (error_count),
        .o_outputs_checked (outputs_checked),
        .o_outputs_pending (outputs_pending),
        .o_wave_steps      (wave_steps)
    );

    // Guard against a hung handshake: give up well past the slowest legal run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_wavetable_sound_channel: errors");
            $finish;
        end
    end

    // Offer one beat at the falling edge, optionally after an idle burst, and
    // hold it until the block takes it at a rising edge.
    task automatic send_beat(input logic [1:0] kind, input logic [2:0] sel,
                             input logic [3:0] addr, input logic [7:0] data);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= kind;
        reg_select   <= sel;
        pattern_addr <= addr;
        write_data   <= data;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        case (kind)
            REQ_TICK:   tick_beats++;
            REQ_LENGTH: length_beats++;
            REQ_REG:    reg_beats++;
            default:    pattern_beats++;
        endcase
    endtask

    // Fields a beat does not use still get random values.
    task automatic send_tick();
        send_beat(REQ_TICK, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_length_clock();
        send_beat(REQ_LENGTH, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic send_reg(input logic [2:0] sel, input logic [7:0] data);
        send_beat(REQ_REG, sel, 4'($urandom_range(0, 15)), data);
    endtask

    task automatic send_pattern(input logic [3:0] addr, input logic [7:0] data);
        send_beat(REQ_PATTERN, 3'($urandom_range(0, 7)), addr, data);
    endtask

    // Drop valid and wait until every predicted output has come back.
    task automatic drain_outputs();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (outputs_pending != 0);
    endtask

    // Register data leaning toward settings that keep the channel busy:
    // DAC on, short lengths, short periods, triggers.
    function automatic logic [7:0] reg_byte(input logic [2:0] sel);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        case (sel)
            REG_DAC:     if ($urandom_range(0, 3) != 0) b[7] = 1'b1;
            REG_LENGTH:  if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(216, 255));
            REG_FREQ_LO: if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(240, 255));
            REG_CONTROL: begin
                if ($urandom_range(0, 3) != 0) begin
                    b[7]   = 1'b1;
                    b[2:0] = 3'd7;
                end
            end
            default: ;
        endcase
        return b;
    endfunction

    // One stretch of random traffic: mostly a register setup followed by a run
    // of ticks, length clocks and pattern writes, sometimes pure noise.
    task automatic send_segment();
        logic [2:0] sel;
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12))
                send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                // full start-up sequence in register order
                send_reg(REG_DAC, reg_byte(REG_DAC));
                send_reg(REG_LENGTH, reg_byte(REG_LENGTH));
                send_reg(REG_VOLUME, reg_byte(REG_VOLUME));
                send_reg(REG_FREQ_LO, reg_byte(REG_FREQ_LO));
                send_reg(REG_CONTROL, reg_byte(REG_CONTROL));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    sel = ($urandom_range(0, 19) == 0)
                        ? 3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST))
                        : 3'($urandom_range(REG_DAC, REG_CONTROL));
                    send_reg(sel, reg_byte(sel));
                end
            end
            repeat ($urandom_range(1, 40)) begin
                pick = $urandom_range(0, 99);
                if (pick < 78)
                    send_tick();
                else if (pick < 92)
                    send_length_clock();
                else
                    send_pattern(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Output side: random stall bursts, long busy stretches, and the one long
    // hold-off on request. Full speed once the quiet tail starts.
    initial begin
        int n;
        wait (rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 14);
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end else begin
                n = quiet ? 1 : $urandom_range(1, 24);
                @(negedge clk);
                out_ready <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;

        // Hold reset, then release it on a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Fill the whole pattern RAM before anything can read it. Nibbles run
        // 0..15 in the high half and 15..0 in the low half.
        for (int b = 0; b < PATTERN_BYTES; b++)
            send_pattern(4'(b), {4'(b), 4'(15 - b)});

        // Period idle after reset: a tick neither counts nor advances.
        send_tick();
        send_reg(REG_VOLUME, 8'h20);        // full volume
        send_tick();                        // channel still disabled: sample muted
        send_reg(REG_CONTROL, 8'h80);       // trigger with the DAC off: no enable
        send_tick();
        send_reg(REG_DAC, 8'h80);
        send_reg(REG_LENGTH, 8'hFF);        // length of one
        send_reg(REG_FREQ_LO, 8'hFF);
        send_reg(REG_CONTROL, 8'hC7);       // trigger, length on, highest frequency
        send_tick();
        send_tick();                        // period expires: next sample
        send_length_clock();                // length runs out: muted
        send_tick();
        send_reg(REG_LENGTH, 8'h00);        // longest length
        send_reg(REG_VOLUME, 8'h40);        // half volume
        send_tick();
        send_tick();
        send_reg(REG_VOLUME, 8'h60);        // quarter volume
        send_tick();
        send_reg(REG_UNUSED_FIRST, 8'hFF);  // unknown registers: only the period reloads
        send_reg(REG_UNUSED_LAST, 8'h00);
        send_pattern(4'd15, 8'hFF);
        send_pattern(4'd0, 8'h00);
        send_reg(REG_FREQ_LO, 8'h00);
        send_reg(REG_CONTROL, 8'h38);       // lowest frequency, length off
        send_tick();
        send_reg(REG_DAC, 8'h7F);           // DAC off disables the channel
        send_tick();
        send_length_clock();

        // Random traffic with the long output stall and one full drain.
        while (items_sent < TOTAL_BEATS) begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_request = 1'b1;
            end
            if (!pause_done && items_sent >= PAUSE_AT) begin
                pause_done = 1'b1;
                drain_outputs();
            end
            quiet = (items_sent >= TOTAL_BEATS - QUIET_BEATS);
            send_segment();
        end

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d ticks, %0d length clocks, %0d register writes,",
                 items_sent, tick_beats, length_beats, reg_beats);
        $display("  %0d pattern writes; compared %0d outputs, wave position stepped %0d times",
                 pattern_beats, outputs_checked, wave_steps);
        if (error_count == 0) begin
            $display("tb_wavetable_sound_channel: clean");
        end else begin
            $display("tb_wavetable_sound_channel: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/wsc_pkg.sv
rtl/wavetable_sound_channel.sv
tb/sv/wavetable_channel_checker.sv
tb/sv/tb_wavetable_sound_channel.sv
